### sv/rsb_pkg.sv
`timescale 1ns / 1ps

package rsb_pkg;

  // Defaults for the top-level parameters.
  localparam int LINE_WIDTH_DEF = 640;
  localparam int MAX_RUN_DEF    = 64;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input item modes.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_RUN   = 1'b1;

  // Result kinds.
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_PAIR   = 1'b1;

  // The run counter sticks at this value.
  localparam logic [9:0] RUNS_MAX = 10'h3FF;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic              is_start;
    logic              active;
    logic              start_draw;
    logic signed [11:0] origin;
    logic [9:0]        width;
    logic              mirror;
    logic [15:0]       color_first;
    logic [15:0]       color_second;
    logic [6:0]        count;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic        active;
    logic [9:0]  addr_first;
    logic        write_first;
    logic [9:0]  addr_second;
    logic        write_second;
    logic [15:0] pixel_first;
    logic [15:0] pixel_second;
    logic        last;
    logic        line_done;
    logic [9:0]  runs_used;
  } res_t;

endpackage

### sv/rsb_if.sv
`timescale 1ns / 1ps

interface rsb_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [9:0]         line;
  logic signed [10:0] pos_x;
  logic signed [10:0] pos_y;
  logic [9:0]         sprite_width;
  logic [9:0]         sprite_height;
  logic               mirror;
  logic [15:0]        color_first;
  logic [15:0]        color_second;
  logic [6:0]         repeat_count;

  modport source (
    output valid, mode, line, pos_x, pos_y, sprite_width, sprite_height, mirror,
           color_first, color_second, repeat_count,
    input  ready
  );
  modport sink (
    input  valid, mode, line, pos_x, pos_y, sprite_width, sprite_height, mirror,
           color_first, color_second, repeat_count,
    output ready
  );
endinterface

interface rsb_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        active;
  logic [9:0]  addr_first;
  logic        write_first;
  logic [9:0]  addr_second;
  logic        write_second;
  logic [15:0] pixel_first;
  logic [15:0] pixel_second;
  logic        last;
  logic        line_done;
  logic [9:0]  runs_used;

  modport source (
    output valid, kind, active, addr_first, write_first, addr_second, write_second,
           pixel_first, pixel_second, last, line_done, runs_used,
    input  ready
  );
  modport sink (
    input  valid, kind, active, addr_first, write_first, addr_second, write_second,
           pixel_first, pixel_second, last, line_done, runs_used,
    output ready
  );
endinterface

### sv/rsb_front.sv
`timescale 1ns / 1ps

module rsb_front import rsb_pkg::*; #(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  rsb_in_if.sink in_i,
  input  logic   q_full_i,
  output logic   push_o,
  output cmd_t   cmd_o
);

  localparam logic [6:0] MaxRun = 7'(MAX_RUN);

  logic signed [12:0] line_s;
  logic signed [12:0] top_s;
  logic signed [12:0] bottom_s;
  logic signed [11:0] x_s;
  logic               act;

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  always_comb begin
    line_s   = $signed({3'b000, in_i.line});
    top_s    = $signed({{2{in_i.pos_y[10]}}, in_i.pos_y});
    bottom_s = top_s + $signed({3'b000, in_i.sprite_height});
    x_s      = $signed({in_i.pos_x[10], in_i.pos_x});
    act      = (line_s > top_s) && (line_s <= bottom_s);

    cmd_o.is_start     = (in_i.mode == MODE_START);
    cmd_o.active       = act;
    cmd_o.start_draw   = act && (in_i.sprite_width != 10'd0);
    cmd_o.origin       = in_i.mirror ? x_s + $signed({2'b00, in_i.sprite_width}) : x_s;
    cmd_o.width        = in_i.sprite_width;
    cmd_o.mirror       = in_i.mirror;
    cmd_o.color_first  = in_i.color_first;
    cmd_o.color_second = in_i.color_second;
    cmd_o.count        = (in_i.repeat_count > MaxRun) ? MaxRun : in_i.repeat_count;
  end

endmodule

### sv/rsb_queue.sv
`timescale 1ns / 1ps

module rsb_queue import rsb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### sv/rsb_back.sv
`timescale 1ns / 1ps

module rsb_back import rsb_pkg::*; #(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        q_valid_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  rsb_out_if.source   out_o
);

  localparam logic [12:0] LineW = 13'(LINE_WIDTH);

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  state_e             state_q, state_d;
  logic               drawing_q, drawing_d;
  logic [10:0]        pos_q, pos_d;
  logic signed [11:0] origin_q, origin_d;
  logic [9:0]         width_q, width_d;
  logic               mirror_q, mirror_d;
  logic [9:0]         runs_q, runs_d;
  logic [6:0]         cnt_q, cnt_d;
  logic [15:0]        c1_q, c1_d;
  logic [15:0]        c2_q, c2_d;
  logic               out_valid_q, out_valid_d;
  res_t               res_q, res_d;
  logic [15:0]        transp_q;

  logic        load;
  logic [9:0]  runs_inc;
  logic [10:0] pos_next;
  logic [9:0]  a1, a2;
  logic        w1, w2;

  // Maps a draw offset to a line address; off-line pixels are never written.
  function automatic void pixel_at(input logic [11:0] offset, input logic [15:0] color,
                                   output logic [9:0] addr, output logic wr);
    logic signed [12:0] o;
    logic signed [12:0] a;
    o = $signed({origin_q[11], origin_q});
    a = mirror_q ? o - $signed({1'b0, offset}) : o + $signed({1'b0, offset});
    if (!a[12] && ($unsigned(a) < LineW)) begin
      addr = a[9:0];
      wr   = (color != transp_q);
    end else begin
      addr = '0;
      wr   = 1'b0;
    end
  endfunction

  assign load     = !out_valid_q || out_o.ready;
  assign runs_inc = (runs_q == RUNS_MAX) ? runs_q : runs_q + 10'd1;
  assign pos_next = pos_q + 11'd2;

  always_comb begin
    pixel_at({1'b0, pos_q}, c1_q, a1, w1);
    pixel_at({1'b0, pos_q} + 12'd1, c2_q, a2, w2);
  end

  always_comb begin
    state_d     = state_q;
    drawing_d   = drawing_q;
    pos_d       = pos_q;
    origin_d    = origin_q;
    width_d     = width_q;
    mirror_d    = mirror_q;
    runs_d      = runs_q;
    cnt_d       = cnt_q;
    c1_d        = c1_q;
    c2_d        = c2_q;
    out_valid_d = out_valid_q && !out_o.ready;
    res_d       = res_q;
    pop_o       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && load) begin
          pop_o = 1'b1;
          if (cmd_i.is_start) begin
            mirror_d        = cmd_i.mirror;
            width_d         = cmd_i.width;
            origin_d        = cmd_i.origin;
            pos_d           = '0;
            runs_d          = '0;
            drawing_d       = cmd_i.start_draw;
            res_d           = '0;
            res_d.kind      = KIND_STATUS;
            res_d.active    = cmd_i.active;
            res_d.last      = 1'b1;
            res_d.line_done = !cmd_i.start_draw;
            out_valid_d     = 1'b1;
          end else if (drawing_q) begin
            runs_d = runs_inc;
            if (cmd_i.count == 7'd0) begin
              if ({1'b0, pos_q} >= {2'b00, width_q}) begin
                drawing_d = 1'b0;
              end
              res_d           = '0;
              res_d.kind      = KIND_STATUS;
              res_d.active    = 1'b1;
              res_d.last      = 1'b1;
              res_d.line_done = (pos_q >= {1'b0, width_q});
              res_d.runs_used = runs_inc;
              out_valid_d     = 1'b1;
            end else begin
              cnt_d   = cmd_i.count;
              c1_d    = cmd_i.color_first;
              c2_d    = cmd_i.color_second;
              state_d = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        if (load) begin
          pos_d              = pos_next;
          cnt_d              = cnt_q - 7'd1;
          res_d.kind         = KIND_PAIR;
          res_d.active       = 1'b1;
          res_d.addr_first   = a1;
          res_d.write_first  = w1;
          res_d.addr_second  = a2;
          res_d.write_second = w2;
          res_d.pixel_first  = c1_q;
          res_d.pixel_second = c2_q;
          res_d.last         = (cnt_q == 7'd1);
          res_d.line_done    = (cnt_q == 7'd1) && (pos_next >= {1'b0, width_q});
          res_d.runs_used    = runs_q;
          out_valid_d        = 1'b1;
          if (cnt_q == 7'd1) begin
            state_d = ST_IDLE;
            if (pos_next >= {1'b0, width_q}) begin
              drawing_d = 1'b0;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      drawing_q   <= 1'b0;
      pos_q       <= '0;
      origin_q    <= '0;
      width_q     <= '0;
      mirror_q    <= 1'b0;
      runs_q      <= '0;
      cnt_q       <= '0;
      c1_q        <= '0;
      c2_q        <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      drawing_q   <= drawing_d;
      pos_q       <= pos_d;
      origin_q    <= origin_d;
      width_q     <= width_d;
      mirror_q    <= mirror_d;
      runs_q      <= runs_d;
      cnt_q       <= cnt_d;
      c1_q        <= c1_d;
      c2_q        <= c2_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transp_q <= '0;
    end else if (cfg_we_i) begin
      transp_q <= cfg_wdata_i;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = res_q.kind;
  assign out_o.active       = res_q.active;
  assign out_o.addr_first   = res_q.addr_first;
  assign out_o.write_first  = res_q.write_first;
  assign out_o.addr_second  = res_q.addr_second;
  assign out_o.write_second = res_q.write_second;
  assign out_o.pixel_first  = res_q.pixel_first;
  assign out_o.pixel_second = res_q.pixel_second;
  assign out_o.last         = res_q.last;
  assign out_o.line_done    = res_q.line_done;
  assign out_o.runs_used    = res_q.runs_used;

endmodule

### sv/rle_sprite_line_blitter.sv
`timescale 1ns / 1ps

// Run-length sprite scanline blitter.
// Requests arrive on in_i: a start request (mode 0) opens a sprite on a line
// and is answered by one status result; run requests (mode 1) then expand into
// pixel-pair writes on out_o, one pair per cycle while out_o is ready, each
// with line buffer addresses and write enables. Runs that arrive while no
// sprite is drawing are dropped without a result. The user is to write the
// transparent color through cfg_we_i / cfg_wdata_i only while the block is
// idle; the block itself does not enforce this.
// A front stage classifies each request into a two-entry command queue, so
// requests keep being accepted while the back stage is busy or the output is
// stalled; the pair expansion in the back stage sets the throughput. The
// status result of a start or zero-count request passes through the command
// queue and the output register; the first pair of a run request also passes
// through the run state of the back stage.
// The output is a register: when the receiver holds ready low, the result
// stays put and the back stage waits, while the queue fills and then holds
// in_i.ready low. Reset clears the queue, the drawing state and the
// transparent color; nothing is drawing after reset.
module rle_sprite_line_blitter import rsb_pkg::*; #(
  parameter int LINE_WIDTH = LINE_WIDTH_DEF,
  parameter int MAX_RUN    = MAX_RUN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  rsb_in_if.sink      in_i,
  rsb_out_if.source   out_o
);

  logic push;
  logic q_full;
  logic q_valid;
  logic pop;
  cmd_t cmd_in;
  cmd_t cmd_out;

  // The front turns each accepted request into a command with its coverage
  // test, origin and saturated repeat count worked out.
  rsb_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  // Short queue that lets the front and back stall independently.
  rsb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (cmd_out)
  );

  // The back holds the line state and expands runs into pixel pairs.
  rsb_back #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule
